[rtl/core/eulr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eulr_pkg;

	// Angles scale into a 32-bit turn before the CORDIC.
	localparam int ANGLE_BITS = 16;
	localparam int DATA_W     = 16;
	localparam int TURN_W     = 32;
	localparam int SCALE_SH   = TURN_W - ANGLE_BITS;

	localparam int N_LANES    = 3;
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;

	// CORDIC datapath: Q2.30 trig with guard bits.
	localparam int STEPS     = 30;
	localparam int TRIG_FRAC = 30;
	localparam int CORE_W    = 34;
	localparam int TRIG_W    = 32;
	localparam int PROD_TW   = 2 * TRIG_W;
	localparam logic signed [CORE_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [CORE_W-1:0] ATAN [STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
		34'sd21354465,  34'sd10679838,  34'sd5340245,   34'sd2670163,  34'sd1335087,
		34'sd667544,    34'sd333772,    34'sd166886,    34'sd83443,    34'sd41722,
		34'sd20861,     34'sd10430,     34'sd5215,      34'sd2608,     34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81,       34'sd41,
		34'sd20,        34'sd10,        34'sd5,         34'sd3,        34'sd1
	};

	// Matrix entries, field products and row sums.
	localparam int MAT_W  = TRIG_W + 1;
	localparam int PROD_W = MAT_W + DATA_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int ROW_W  = SUM_W - TRIG_FRAC;
	localparam int MEAS_W = ROW_W + 1;

	// Configuration register indexes.
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_FIELD_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_FIELD_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_FIELD_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_BIAS_X  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BIAS_Y  = 3'd4;
	localparam logic [IDX_W-1:0] REG_BIAS_Z  = 3'd5;

	localparam logic signed [DATA_W-1:0] FIELD_ONE = 16'sd16384;

	typedef struct packed {
		logic signed [DATA_W-1:0] roll_angle;
		logic signed [DATA_W-1:0] pitch_angle;
		logic signed [DATA_W-1:0] yaw_angle;
	} angles_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] meas_x;
		logic signed [DATA_W-1:0] meas_y;
		logic signed [DATA_W-1:0] meas_z;
		logic signed [DATA_W-1:0] dyaw_x;
		logic signed [DATA_W-1:0] dyaw_y;
		logic signed [DATA_W-1:0] dyaw_z;
	} meas_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] field_x;
		logic signed [DATA_W-1:0] field_y;
		logic signed [DATA_W-1:0] field_z;
		logic signed [DATA_W-1:0] bias_x;
		logic signed [DATA_W-1:0] bias_y;
		logic signed [DATA_W-1:0] bias_z;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [MAT_W-1:0] m11;
		logic signed [MAT_W-1:0] m12;
		logic signed [MAT_W-1:0] m13;
		logic signed [MAT_W-1:0] m21;
		logic signed [MAT_W-1:0] m22;
		logic signed [MAT_W-1:0] m23;
		logic signed [MAT_W-1:0] m31;
		logic signed [MAT_W-1:0] m32;
		logic signed [MAT_W-1:0] m33;
	} dcm_t;

	// Q2.30 product, rounded half up back to Q2.30.
	function automatic logic signed [TRIG_W-1:0] qmul(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [PROD_TW-1:0] p;
		p = PROD_TW'(a) * PROD_TW'(b) + (PROD_TW'(1) <<< (TRIG_FRAC - 1));
		return p[TRIG_W+TRIG_FRAC-1:TRIG_FRAC];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [MEAS_W-1:0] v);
		logic signed [MEAS_W-1:0] hi;
		logic signed [MEAS_W-1:0] lo;
		hi = MEAS_W'(2 ** (DATA_W - 1) - 1);
		lo = -MEAS_W'(2 ** (DATA_W - 1));
		if (v > hi)
			return hi[DATA_W-1:0];
		else if (v < lo)
			return lo[DATA_W-1:0];
		else
			return v[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/eulr_angle_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface eulr_angle_if;
	logic             valid;
	logic             ready;
	eulr_pkg::angles_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/eulr_meas_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface eulr_meas_if;
	logic            valid;
	logic            ready;
	eulr_pkg::meas_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/eulr_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface eulr_cfg_if;
	logic              valid;
	logic              ready;
	eulr_pkg::cfg_wr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/euler_rotate_field_vector.sv]
// An accepted item passes through the CORDIC, matrix and projection stages to its result on meas.
// Throughput: one item per cycle; the whole pipeline holds while the result waits on meas.ready.
// Up to 36 items are in flight; the last projection stage is the output register.
// Reset (arst_n low, asynchronous): all stage valid bits clear, field = (1.0, 0, 0), bias = 0.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module euler_rotate_field_vector (
	input var logic       clk,
	input var logic       arst_n,
	eulr_angle_if.sink    angles,
	eulr_meas_if.source   meas,
	eulr_cfg_if.sink      cfg
);

	// Global advance: move every stage when the output register is empty or
	// its item is being taken; otherwise hold everything in place.
	logic en;
	logic out_vld;

	logic                                   cordic_vld;
	logic signed [eulr_pkg::TRIG_W-1:0]     sin_val [eulr_pkg::N_LANES];
	logic signed [eulr_pkg::TRIG_W-1:0]     cos_val [eulr_pkg::N_LANES];
	logic                                   dcm_vld;
	eulr_pkg::dcm_t                         dcm;
	eulr_pkg::cfg_regs_t                    regs_q;
	eulr_pkg::meas_t                        meas_data;

	assign en           = !out_vld || meas.ready;
	assign angles.ready = en;
	assign cfg.ready    = 1'b1;
	assign meas.valid   = out_vld;
	assign meas.data    = meas_data;

	// Configuration registers; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.field_x <= eulr_pkg::FIELD_ONE;
			regs_q.field_y <= '0;
			regs_q.field_z <= '0;
			regs_q.bias_x  <= '0;
			regs_q.bias_y  <= '0;
			regs_q.bias_z  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				eulr_pkg::REG_FIELD_X: regs_q.field_x <= signed'(cfg.data.value);
				eulr_pkg::REG_FIELD_Y: regs_q.field_y <= signed'(cfg.data.value);
				eulr_pkg::REG_FIELD_Z: regs_q.field_z <= signed'(cfg.data.value);
				eulr_pkg::REG_BIAS_X:  regs_q.bias_x  <= signed'(cfg.data.value);
				eulr_pkg::REG_BIAS_Y:  regs_q.bias_y  <= signed'(cfg.data.value);
				eulr_pkg::REG_BIAS_Z:  regs_q.bias_z  <= signed'(cfg.data.value);
				default: ;
			endcase
		end
	end

	// Sine and cosine of roll, pitch and yaw in Q2.30.
	eulr_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (angles.valid),
		.angles    (angles.data),
		.out_valid (cordic_vld),
		.sin_val   (sin_val),
		.cos_val   (cos_val)
	);

	// Direction-cosine matrix entries.
	eulr_dcm u_dcm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cordic_vld),
		.sin_val   (sin_val),
		.cos_val   (cos_val),
		.out_valid (dcm_vld),
		.dcm       (dcm)
	);

	// Field projection, bias, yaw derivatives and saturation.
	eulr_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dcm_vld),
		.dcm       (dcm),
		.regs      (regs_q),
		.out_valid (out_vld),
		.meas      (meas_data)
	);

endmodule

`default_nettype wire

[rtl/core/eulr_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

// Three-lane rotation-mode CORDIC, one iteration per stage.
module eulr_cordic (
	input  var logic                                clk,
	input  var logic                                arst_n,
	input  var logic                                en,
	input  var logic                                in_valid,
	input  var eulr_pkg::angles_t                   angles,
	output logic                                    out_valid,
	output logic signed [eulr_pkg::TRIG_W-1:0]      sin_val [eulr_pkg::N_LANES],
	output logic signed [eulr_pkg::TRIG_W-1:0]      cos_val [eulr_pkg::N_LANES]
);

	localparam int NL = eulr_pkg::N_LANES;
	localparam int NS = eulr_pkg::STEPS;
	localparam int CW = eulr_pkg::CORE_W;
	localparam int TW = eulr_pkg::TURN_W;

	logic signed [eulr_pkg::DATA_W-1:0] ang [NL];
	logic        [TW-1:0]               a_turn [NL];
	logic                               flip_c [NL];
	logic signed [CW-1:0]               z0_c [NL];

	logic signed [CW-1:0] x_s [NL][NS+1];
	logic signed [CW-1:0] y_s [NL][NS+1];
	logic signed [CW-1:0] z_s [NL][NS+1];
	logic                 flip_s [NL][NS+1];
	logic [NS+1:0]        vld_s;

	assign ang[eulr_pkg::LANE_ROLL]  = angles.roll_angle;
	assign ang[eulr_pkg::LANE_PITCH] = angles.pitch_angle;
	assign ang[eulr_pkg::LANE_YAW]   = angles.yaw_angle;

	// Fold the left half-plane onto the right by a half turn.
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			a_turn[l] = TW'(ang[l]) << eulr_pkg::SCALE_SH;
			flip_c[l] = a_turn[l][TW-1] ^ a_turn[l][TW-2];
			z0_c[l]   = CW'(signed'({a_turn[l][TW-1] ^ flip_c[l], a_turn[l][TW-2:0]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				x_s[l][0]    <= eulr_pkg::CORDIC_GAIN;
				y_s[l][0]    <= '0;
				z_s[l][0]    <= z0_c[l];
				flip_s[l][0] <= flip_c[l];
				for (int i = 0; i < NS; i++) begin
					flip_s[l][i+1] <= flip_s[l][i];
					if (!z_s[l][i][CW-1]) begin
						x_s[l][i+1] <= x_s[l][i] - (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] + (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] - eulr_pkg::ATAN[i];
					end else begin
						x_s[l][i+1] <= x_s[l][i] + (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] - (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] + eulr_pkg::ATAN[i];
					end
				end
				// Undo the half-turn fold.
				if (flip_s[l][NS]) begin
					sin_val[l] <= eulr_pkg::TRIG_W'(-y_s[l][NS]);
					cos_val[l] <= eulr_pkg::TRIG_W'(-x_s[l][NS]);
				end else begin
					sin_val[l] <= eulr_pkg::TRIG_W'(y_s[l][NS]);
					cos_val[l] <= eulr_pkg::TRIG_W'(x_s[l][NS]);
				end
			end
		end
	end

	assign out_valid = vld_s[NS+1];

endmodule

`default_nettype wire

[rtl/core/eulr_dcm.sv]
`timescale 1ns / 1ps
`default_nettype none

// ZYX direction-cosine matrix in two product stages.
module eulr_dcm (
	input  var logic                               clk,
	input  var logic                               arst_n,
	input  var logic                               en,
	input  var logic                               in_valid,
	input  var logic signed [eulr_pkg::TRIG_W-1:0] sin_val [eulr_pkg::N_LANES],
	input  var logic signed [eulr_pkg::TRIG_W-1:0] cos_val [eulr_pkg::N_LANES],
	output logic                                   out_valid,
	output eulr_pkg::dcm_t                         dcm
);

	localparam int TW = eulr_pkg::TRIG_W;
	localparam int MW = eulr_pkg::MAT_W;

	logic signed [TW-1:0] sr_s1, cr_s1, sp_s1, sa_s1, ca_s1;
	logic signed [TW-1:0] srsp_s1, crsp_s1, m11_s1, m12_s1, m23_s1, m33_s1;
	logic                 vld_s1, vld_s2;
	eulr_pkg::dcm_t       dcm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s1   <= sin_val[eulr_pkg::LANE_ROLL];
			cr_s1   <= cos_val[eulr_pkg::LANE_ROLL];
			sp_s1   <= sin_val[eulr_pkg::LANE_PITCH];
			sa_s1   <= sin_val[eulr_pkg::LANE_YAW];
			ca_s1   <= cos_val[eulr_pkg::LANE_YAW];
			srsp_s1 <= eulr_pkg::qmul(sin_val[eulr_pkg::LANE_ROLL], sin_val[eulr_pkg::LANE_PITCH]);
			crsp_s1 <= eulr_pkg::qmul(cos_val[eulr_pkg::LANE_ROLL], sin_val[eulr_pkg::LANE_PITCH]);
			m11_s1  <= eulr_pkg::qmul(cos_val[eulr_pkg::LANE_PITCH], cos_val[eulr_pkg::LANE_YAW]);
			m12_s1  <= eulr_pkg::qmul(cos_val[eulr_pkg::LANE_PITCH], sin_val[eulr_pkg::LANE_YAW]);
			m23_s1  <= eulr_pkg::qmul(sin_val[eulr_pkg::LANE_ROLL], cos_val[eulr_pkg::LANE_PITCH]);
			m33_s1  <= eulr_pkg::qmul(cos_val[eulr_pkg::LANE_ROLL], cos_val[eulr_pkg::LANE_PITCH]);

			dcm_s2.m11 <= MW'(m11_s1);
			dcm_s2.m12 <= MW'(m12_s1);
			dcm_s2.m13 <= -MW'(sp_s1);
			dcm_s2.m21 <= MW'(eulr_pkg::qmul(srsp_s1, ca_s1)) - MW'(eulr_pkg::qmul(cr_s1, sa_s1));
			dcm_s2.m22 <= MW'(eulr_pkg::qmul(srsp_s1, sa_s1)) + MW'(eulr_pkg::qmul(cr_s1, ca_s1));
			dcm_s2.m23 <= MW'(m23_s1);
			dcm_s2.m31 <= MW'(eulr_pkg::qmul(crsp_s1, ca_s1)) + MW'(eulr_pkg::qmul(sr_s1, sa_s1));
			dcm_s2.m32 <= MW'(eulr_pkg::qmul(crsp_s1, sa_s1)) - MW'(eulr_pkg::qmul(sr_s1, ca_s1));
			dcm_s2.m33 <= MW'(m33_s1);
		end
	end

	assign out_valid = vld_s2;
	assign dcm       = dcm_s2;

endmodule

`default_nettype wire

[rtl/core/eulr_proj.sv]
`timescale 1ns / 1ps
`default_nettype none

// Matrix times reference field, bias, saturation; last stage is the output register.
module eulr_proj (
	input  var logic               clk,
	input  var logic               arst_n,
	input  var logic               en,
	input  var logic               in_valid,
	input  var eulr_pkg::dcm_t     dcm,
	input  var eulr_pkg::cfg_regs_t regs,
	output logic                   out_valid,
	output eulr_pkg::meas_t        meas
);

	localparam int PW = eulr_pkg::PROD_W;
	localparam int SW = eulr_pkg::SUM_W;
	localparam int RW = eulr_pkg::ROW_W;
	localparam int QW = eulr_pkg::MEAS_W;
	localparam int FR = eulr_pkg::TRIG_FRAC;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FR - 1);

	logic signed [PW-1:0] p11x_s1, p12y_s1, p13z_s1;
	logic signed [PW-1:0] p21x_s1, p22y_s1, p23z_s1;
	logic signed [PW-1:0] p31x_s1, p32y_s1, p33z_s1;
	logic signed [PW-1:0] p12x_s1, p11y_s1, p22x_s1, p21y_s1, p32x_s1, p31y_s1;
	logic                 vld_s1, vld_s2;
	eulr_pkg::meas_t      meas_s2;

	logic signed [SW-1:0] sum_c [6];
	logic signed [RW-1:0] row_c [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p11x_s1 <= PW'(dcm.m11) * PW'(regs.field_x);
			p12y_s1 <= PW'(dcm.m12) * PW'(regs.field_y);
			p13z_s1 <= PW'(dcm.m13) * PW'(regs.field_z);
			p21x_s1 <= PW'(dcm.m21) * PW'(regs.field_x);
			p22y_s1 <= PW'(dcm.m22) * PW'(regs.field_y);
			p23z_s1 <= PW'(dcm.m23) * PW'(regs.field_z);
			p31x_s1 <= PW'(dcm.m31) * PW'(regs.field_x);
			p32y_s1 <= PW'(dcm.m32) * PW'(regs.field_y);
			p33z_s1 <= PW'(dcm.m33) * PW'(regs.field_z);
			p12x_s1 <= PW'(dcm.m12) * PW'(regs.field_x);
			p11y_s1 <= PW'(dcm.m11) * PW'(regs.field_y);
			p22x_s1 <= PW'(dcm.m22) * PW'(regs.field_x);
			p21y_s1 <= PW'(dcm.m21) * PW'(regs.field_y);
			p32x_s1 <= PW'(dcm.m32) * PW'(regs.field_x);
			p31y_s1 <= PW'(dcm.m31) * PW'(regs.field_y);
		end
	end

	// Exact row sums, rounded half up to the field's fraction.
	always_comb begin
		sum_c[0] = SW'(p11x_s1) + SW'(p12y_s1) + SW'(p13z_s1) + HALF;
		sum_c[1] = SW'(p21x_s1) + SW'(p22y_s1) + SW'(p23z_s1) + HALF;
		sum_c[2] = SW'(p31x_s1) + SW'(p32y_s1) + SW'(p33z_s1) + HALF;
		sum_c[3] = SW'(p11y_s1) - SW'(p12x_s1) + HALF;
		sum_c[4] = SW'(p21y_s1) - SW'(p22x_s1) + HALF;
		sum_c[5] = SW'(p31y_s1) - SW'(p32x_s1) + HALF;
		for (int k = 0; k < 6; k++)
			row_c[k] = sum_c[k][SW-1:FR];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meas_s2.meas_x <= eulr_pkg::sat16(QW'(row_c[0]) + QW'(regs.bias_x));
			meas_s2.meas_y <= eulr_pkg::sat16(QW'(row_c[1]) + QW'(regs.bias_y));
			meas_s2.meas_z <= eulr_pkg::sat16(QW'(row_c[2]) + QW'(regs.bias_z));
			meas_s2.dyaw_x <= eulr_pkg::sat16(QW'(row_c[3]));
			meas_s2.dyaw_y <= eulr_pkg::sat16(QW'(row_c[4]));
			meas_s2.dyaw_z <= eulr_pkg::sat16(QW'(row_c[5]));
		end
	end

	assign out_valid = vld_s2;
	assign meas      = meas_s2;

endmodule

`default_nettype wire
